>>> rtl/tti_pkg.sv
// Shared types, constants and the digit decoder for the text-to-integer unit.
// Depends on nothing; every other file of the unit imports it.
`timescale 1ns / 1ps
package tti_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int MAX_LEN_DEF     = 4096;

   localparam int CHAR_WIDTH      = 8;
   localparam int RADIX_WIDTH     = 6;
   localparam int OFFSET_WIDTH    = 12;
   localparam int STATUS_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int RESULT_WIDTH    = 64;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_WIDTH-1:0] RADIX_ONE   = 6'd1;
   localparam logic [RADIX_WIDTH-1:0] RADIX_DEC   = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_HEX   = 6'd16;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] NOT_DIGIT   = 6'd36;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR      = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CASE    = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_A_LOWER = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_Z_LOWER = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X_UPPER = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X_LOWER = 8'h78;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RADIX    = 4'd0,
      CSR_UNSIGNED = 4'd1
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_OK  = 2'd0,
      STAT_SAT = 2'd1,
      STAT_BAD = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_WS   = 3'd0,
      PH_SIGN = 3'd1,
      PH_LEAD = 3'd2,
      PH_X    = 3'd3,
      PH_DIG  = 3'd4,
      PH_DONE = 3'd5,
      PH_BAD  = 3'd6
   } phase_type;

   // Per-string control state handed between the step logic and its registers.
   typedef struct packed {
      phase_type                phase;
      logic                     negative;
      logic                     saturated;
      logic                     unsigned_mode;
      logic [RADIX_WIDTH-1:0]   active_radix;
   } ctl_type;

   // Digit value of a character, case folded; NOT_DIGIT for anything else.
   function automatic logic [RADIX_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] lc;
      logic [CHAR_WIDTH-1:0] diff;
      lc = c | CHAR_CASE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         return diff[RADIX_WIDTH-1:0];
      end else if (lc >= CHAR_A_LOWER && lc <= CHAR_Z_LOWER) begin
         diff = lc - CHAR_A_LOWER + 8'd10;
         return diff[RADIX_WIDTH-1:0];
      end else begin
         return NOT_DIGIT;
      end
   endfunction

endpackage

>>> rtl/tti_req_if.sv
// Character input channel: valid/ready handshake carrying one byte per beat.
// Uses tti_pkg for the character width.
`timescale 1ns / 1ps
interface tti_req_if import tti_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

>>> rtl/tti_rsp_if.sv
// Result channel: valid/ready handshake carrying value, end offset and status.
// Uses tti_pkg for the field widths.
`timescale 1ns / 1ps
interface tti_rsp_if import tti_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [RESULT_WIDTH-1:0] value;
   logic [OFFSET_WIDTH-1:0] end_offset;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, output value, output end_offset, output status, input ready);
   modport sink   (input valid, input value, input end_offset, input status, output ready);
endinterface

>>> rtl/tti_csr_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Uses tti_pkg for the field widths.
`timescale 1ns / 1ps
interface tti_csr_if import tti_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/tti_step.sv
// Next-state and result logic for one character of the string.
// Purely combinational; uses tti_pkg types, constants and digit_of.
`timescale 1ns / 1ps
module tti_step import tti_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_LEN     = MAX_LEN_DEF,
   localparam int POS_WIDTH  = $clog2(MAX_LEN)
) (
   input  logic [CHAR_WIDTH-1:0]   char_code,
   input  logic [RADIX_WIDTH-1:0]  cfg_radix,
   input  logic                    cfg_unsigned,
   input  ctl_type                 ctl_cur,
   input  logic [VALUE_WIDTH-1:0]  acc_cur,
   input  logic [POS_WIDTH-1:0]    pos_cur,
   input  logic [POS_WIDTH-1:0]    stop_cur,
   output ctl_type                 ctl_next,
   output logic [VALUE_WIDTH-1:0]  acc_next,
   output logic [POS_WIDTH-1:0]    pos_next,
   output logic [POS_WIDTH-1:0]    stop_next,
   output logic                    is_end,
   output logic [RESULT_WIDTH-1:0] res_value,
   output logic [OFFSET_WIDTH-1:0] res_offset,
   output status_type              res_status
);

   localparam logic [POS_WIDTH-1:0] POS_LAST = POS_WIDTH'(MAX_LEN - 1);
   localparam int SUM_WIDTH = VALUE_WIDTH + RADIX_WIDTH + 1;

   ctl_type                        ctl;
   logic                           done;
   logic                           is_space;
   logic [POS_WIDTH-1:0]           pos_inc;
   logic [RADIX_WIDTH-1:0]         digit;
   logic [VALUE_WIDTH-1:0]         limit;
   logic [VALUE_WIDTH+RADIX_WIDTH-1:0] product;
   logic [SUM_WIDTH-1:0]           sum;
   logic [VALUE_WIDTH-1:0]         signed_val;
   logic [POS_WIDTH+OFFSET_WIDTH-1:0] stop_wide;
   logic [VALUE_WIDTH-1:0]         acc_work;
   logic [POS_WIDTH-1:0]           stop_work;

   assign pos_inc  = (pos_cur < POS_LAST) ? pos_cur + 1'b1 : pos_cur;
   assign is_space = (char_code == CHAR_SPACE) ||
                     (char_code >= CHAR_TAB && char_code <= CHAR_CR);
   assign digit    = digit_of(char_code);
   assign is_end   = (char_code == CHAR_NUL);

   always_comb begin
      ctl = ctl_cur;
      // The first byte of a string picks up the configuration.
      if (pos_cur == '0) begin
         ctl.active_radix  = cfg_radix;
         ctl.unsigned_mode = cfg_unsigned;
         if (cfg_radix == RADIX_ONE || cfg_radix > RADIX_MAX) begin
            ctl.phase = PH_BAD;
         end
      end

      // Result on the terminating byte.
      signed_val = ctl.negative ? (VALUE_WIDTH'(0) - acc_cur) : acc_cur;
      stop_wide  = {{OFFSET_WIDTH{1'b0}}, stop_cur};
      if (ctl.phase == PH_BAD) begin
         res_value  = '0;
         res_offset = '0;
         res_status = STAT_BAD;
      end else begin
         res_value  = RESULT_WIDTH'(signed_val);
         res_offset = stop_wide[OFFSET_WIDTH-1:0];
         res_status = ctl.saturated ? STAT_SAT : STAT_OK;
      end

      // Walk the phases; a phase that does not consume the byte falls through.
      done      = 1'b0;
      acc_work  = acc_cur;
      stop_work = stop_cur;
      if (ctl.phase == PH_WS) begin
         if (is_space) begin
            done = 1'b1;
         end else begin
            ctl.phase = PH_SIGN;
         end
      end
      if (!done && ctl.phase == PH_SIGN) begin
         ctl.phase = PH_LEAD;
         if (!ctl.unsigned_mode && (char_code == CHAR_PLUS || char_code == CHAR_MINUS)) begin
            ctl.negative = (char_code == CHAR_MINUS);
            done = 1'b1;
         end
      end
      if (!done && ctl.phase == PH_LEAD) begin
         if ((ctl.active_radix == RADIX_AUTO || ctl.active_radix == RADIX_HEX) &&
             char_code == CHAR_ZERO) begin
            stop_work = pos_inc;
            ctl.phase = PH_X;
            done      = 1'b1;
         end else begin
            if (ctl.active_radix == RADIX_AUTO) begin
               ctl.active_radix = RADIX_DEC;
            end
            ctl.phase = PH_DIG;
         end
      end
      if (!done && ctl.phase == PH_X) begin
         if (char_code == CHAR_X_LOWER || char_code == CHAR_X_UPPER) begin
            ctl.active_radix = RADIX_HEX;
            done = 1'b1;
         end else if (ctl.active_radix == RADIX_AUTO) begin
            ctl.active_radix = RADIX_DEC;
         end
         ctl.phase = PH_DIG;
      end

      // Saturation bound for the current sign and mode.
      if (ctl.unsigned_mode) begin
         limit = '1;
      end else if (ctl.negative) begin
         limit = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         limit = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
      product = (VALUE_WIDTH+RADIX_WIDTH)'(acc_cur) * (VALUE_WIDTH+RADIX_WIDTH)'(ctl.active_radix);
      sum     = SUM_WIDTH'(product) + SUM_WIDTH'(digit);

      if (!done && ctl.phase == PH_DIG) begin
         if (digit < ctl.active_radix) begin
            if (sum > SUM_WIDTH'(limit)) begin
               acc_work      = limit;
               ctl.saturated = 1'b1;
            end else begin
               acc_work = sum[VALUE_WIDTH-1:0];
            end
            stop_work = pos_inc;
         end else begin
            ctl.phase = PH_DONE;
         end
      end

      // Terminating byte: clear for the next string.
      if (is_end) begin
         ctl_next.phase         = PH_WS;
         ctl_next.negative      = 1'b0;
         ctl_next.saturated     = 1'b0;
         ctl_next.unsigned_mode = 1'b0;
         ctl_next.active_radix  = RADIX_AUTO;
         acc_next  = '0;
         pos_next  = '0;
         stop_next = '0;
      end else begin
         ctl_next  = ctl;
         acc_next  = acc_work;
         pos_next  = pos_inc;
         stop_next = stop_work;
      end
   end

endmodule

>>> rtl/text_to_integer_radix_unit.sv
// A terminating NUL beat goes from the input register into the result register and
// leaves as a result beat. Throughput: one character per cycle unless a NUL waits on
// a full result slot; the multiply-add in the step logic between the input register
// and the per-string state is the only path of note.
// Reset (synchronous, active high): radix 10, signed mode, both channels empty.
// Depends on tti_pkg, tti_req_if, tti_rsp_if, tti_csr_if and tti_step.
`timescale 1ns / 1ps
module text_to_integer_radix_unit import tti_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_LEN     = MAX_LEN_DEF
) (
   input logic         clock,
   input logic         reset,
   tti_req_if.sink     req_bus,
   tti_rsp_if.source   rsp_bus,
   tti_csr_if.sink     csr_bus
);

   localparam int POS_WIDTH = $clog2(MAX_LEN);

   // Configuration registers.
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic                   unsigned_ff, unsigned_in;

   // Input register: holds one character beat.
   logic                   in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0]  in_char_ff, in_char_in;

   // Per-string state.
   ctl_type                ctl_ff, ctl_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   stop_ff, stop_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [OFFSET_WIDTH-1:0] rsp_offset_ff, rsp_offset_in;
   status_type              rsp_status_ff, rsp_status_in;

   // Step logic outputs.
   ctl_type                 step_ctl;
   logic [VALUE_WIDTH-1:0]  step_acc;
   logic [POS_WIDTH-1:0]    step_pos;
   logic [POS_WIDTH-1:0]    step_stop;
   logic                    step_end;
   logic [RESULT_WIDTH-1:0] step_value;
   logic [OFFSET_WIDTH-1:0] step_offset;
   status_type              step_status;

   logic out_free;
   logic advance;
   logic take_req;

   tti_step #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_LEN     (MAX_LEN)
   ) u_step (
      .char_code    (in_char_ff),
      .cfg_radix    (radix_ff),
      .cfg_unsigned (unsigned_ff),
      .ctl_cur      (ctl_ff),
      .acc_cur      (acc_ff),
      .pos_cur      (pos_ff),
      .stop_cur     (stop_ff),
      .ctl_next     (step_ctl),
      .acc_next     (step_acc),
      .pos_next     (step_pos),
      .stop_next    (step_stop),
      .is_end       (step_end),
      .res_value    (step_value),
      .res_offset   (step_offset),
      .res_status   (step_status)
   );

   // The result slot frees up when empty or when its beat is taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   // A held character advances unless it is a NUL waiting on a full result slot.
   assign advance  = in_valid_ff && (!step_end || out_free);
   // Take a new beat whenever the held one leaves, so characters stream back to back.
   assign take_req = req_bus.valid && req_bus.ready;

   assign req_bus.ready      = !in_valid_ff || advance;
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.value      = rsp_value_ff;
   assign rsp_bus.end_offset = rsp_offset_ff;
   assign rsp_bus.status     = rsp_status_ff;

   // Configuration writes; indexes past the list are dropped.
   always_comb begin
      radix_in    = radix_ff;
      unsigned_in = unsigned_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_RADIX:    radix_in    = csr_bus.data[RADIX_WIDTH-1:0];
            CSR_UNSIGNED: unsigned_in = csr_bus.data[0];
            default:      ;
         endcase
      end
   end

   // Input register: load on a taken beat, drop once the held one advances.
   always_comb begin
      in_char_in  = take_req ? req_bus.char_code : in_char_ff;
      in_valid_in = take_req || (in_valid_ff && !advance);
   end

   // Per-string state: advance with every processed character.
   always_comb begin
      ctl_in  = advance ? step_ctl  : ctl_ff;
      acc_in  = advance ? step_acc  : acc_ff;
      pos_in  = advance ? step_pos  : pos_ff;
      stop_in = advance ? step_stop : stop_ff;
   end

   // Result register: load on NUL, clear the valid once the beat is taken.
   always_comb begin
      rsp_value_in  = rsp_value_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      if (advance && step_end) begin
         rsp_value_in  = step_value;
         rsp_offset_in = step_offset;
         rsp_status_in = step_status;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff              <= RADIX_RESET;
         unsigned_ff           <= 1'b0;
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         ctl_ff.phase          <= PH_WS;
         ctl_ff.negative       <= 1'b0;
         ctl_ff.saturated      <= 1'b0;
         ctl_ff.unsigned_mode  <= 1'b0;
         ctl_ff.active_radix   <= RADIX_AUTO;
         acc_ff                <= '0;
         pos_ff                <= '0;
         stop_ff               <= '0;
      end else begin
         radix_ff     <= radix_in;
         unsigned_ff  <= unsigned_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctl_ff       <= ctl_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         stop_ff      <= stop_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      in_char_ff    <= in_char_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The stop point never runs ahead of the character position.
   a_stop_le_pos: assert property (@(posedge clock) disable iff (reset)
      stop_ff <= pos_ff)
      else $error("stop position ahead of character position");

   // A bad radix never accumulates digits.
   a_bad_no_acc: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.phase == PH_BAD) |-> (acc_ff == '0))
      else $error("accumulator moved under an invalid radix");

   // A processed NUL produces a result and rewinds the position.
   a_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      (advance && step_end) |=> (rsp_valid_ff && pos_ff == '0))
      else $error("terminator did not produce a result or rewind");

   // Invalid radix results carry zero value and offset.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_BAD) |->
         (rsp_value_ff == '0 && rsp_offset_ff == '0))
      else $error("invalid radix result is not zero");

endmodule

>>> test/tb_text_to_integer_radix_unit.sv
// Self-checking bench for text_to_integer_radix_unit: character strings in, parsed results out.
// Depends on tti_pkg and the tti_req_if, tti_rsp_if and tti_csr_if channel interfaces.
`timescale 1ns / 1ps
module tb_text_to_integer_radix_unit;
   import tti_pkg::*;

   localparam int VALUE_W       = VALUE_WIDTH_DEF;
   localparam int STR_MAX       = MAX_LEN_DEF;
   localparam int PHASE_CHARS   = 100;
   localparam int SETTLE_CYCLES = 4;
   localparam int TIMEOUT_NS    = 5_000_000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [RESULT_WIDTH-1:0] VAL_MASK = {RESULT_WIDTH{1'b1}} >> (64 - VALUE_W);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 4'd5;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] value;
      logic [OFFSET_WIDTH-1:0] end_offset;
      logic [STATUS_WIDTH-1:0] status;
   } parse_result_type;

   logic clock;
   logic reset;

   tti_req_if req_bus ();
   tti_rsp_if rsp_bus ();
   tti_csr_if csr_bus ();

   text_to_integer_radix_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Characters waiting for the driver, and results waiting for the monitor.
   logic [CHAR_WIDTH-1:0] pending_chars[$];
   parse_result_type      expected_results[$];

   int unsigned chars_queued;
   int unsigned chars_accepted;
   int unsigned error_count;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // Register settings the bench walks through, one per phase; the rest are random.
   logic [RADIX_WIDTH-1:0] radix_plan [12] = '{RADIX_AUTO, RADIX_HEX, 6'd2, RADIX_MAX,
                                                RADIX_DEC, RADIX_ONE, 6'd8, 6'd37,
                                                RADIX_AUTO, RADIX_HEX, 6'd63, RADIX_MAX};
   logic                   unsigned_plan [12] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                                                  1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

   // Mirror of the block's registers and per-string parse state.
   logic [RADIX_WIDTH-1:0]  cfg_radix;
   logic                    cfg_unsigned;
   phase_type               prs_phase;
   logic [RESULT_WIDTH-1:0] prs_acc;
   logic                    prs_neg;
   logic                    prs_sat;
   logic                    prs_unsigned;
   logic [RADIX_WIDTH-1:0]  prs_radix;
   int unsigned             prs_pos;
   int unsigned             prs_stop;

   // ------------------------------------------------------------------
   // Parse predictor
   // ------------------------------------------------------------------

   function automatic void restart_string();
      prs_phase    = PH_WS;
      prs_acc      = '0;
      prs_neg      = 1'b0;
      prs_sat      = 1'b0;
      prs_unsigned = 1'b0;
      prs_radix    = '0;
      prs_pos      = 0;
      prs_stop     = 0;
   endfunction

   // Positions stick at the last index of the string buffer.
   function automatic int unsigned bumped(int unsigned p);
      return (p < STR_MAX - 1) ? p + 1 : p;
   endfunction

   function automatic int unsigned char_value(logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] folded;
      folded = c | CHAR_CASE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return c - CHAR_ZERO;
      end else if (folded >= CHAR_A_LOWER && folded <= CHAR_Z_LOWER) begin
         return folded - CHAR_A_LOWER + 10;
      end
      return NOT_DIGIT;
   endfunction

   // Exact overflow test against the limit for the current sign and mode.
   function automatic void accumulate_digit(int unsigned d);
      logic [RESULT_WIDTH-1:0] lim;
      if (prs_unsigned) begin
         lim = VAL_MASK;
      end else if (prs_neg) begin
         lim = (VAL_MASK >> 1) + 1;
      end else begin
         lim = VAL_MASK >> 1;
      end
      if (prs_acc > (lim - 64'(d)) / 64'(prs_radix)) begin
         prs_acc = lim;
         prs_sat = 1'b1;
      end else begin
         prs_acc = prs_acc * 64'(prs_radix) + 64'(d);
      end
      prs_stop = bumped(prs_pos);
   endfunction

   // Walk the parse phases; a byte that only moves the phase on is looked at again.
   function automatic void feed_char(logic [CHAR_WIDTH-1:0] c);
      bit          again;
      int unsigned d;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (prs_phase)
            PH_WS: begin
               if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
                  prs_phase = PH_SIGN;
                  again     = 1'b1;
               end
            end
            PH_SIGN: begin
               prs_phase = PH_LEAD;
               if (!prs_unsigned && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                  prs_neg = (c == CHAR_MINUS);
               end else begin
                  again = 1'b1;
               end
            end
            PH_LEAD: begin
               if ((prs_radix == RADIX_AUTO || prs_radix == RADIX_HEX) && c == CHAR_ZERO) begin
                  prs_stop  = bumped(prs_pos);
                  prs_phase = PH_X;
               end else begin
                  if (prs_radix == RADIX_AUTO) prs_radix = RADIX_DEC;
                  prs_phase = PH_DIG;
                  again     = 1'b1;
               end
            end
            PH_X: begin
               if (c == CHAR_X_LOWER || c == CHAR_X_UPPER) begin
                  prs_radix = RADIX_HEX;
                  prs_phase = PH_DIG;
               end else begin
                  if (prs_radix == RADIX_AUTO) prs_radix = RADIX_DEC;
                  prs_phase = PH_DIG;
                  again     = 1'b1;
               end
            end
            PH_DIG: begin
               d = char_value(c);
               if (d < prs_radix) begin
                  accumulate_digit(d);
               end else begin
                  prs_phase = PH_DONE;
               end
            end
            default: ;
         endcase
      end
   endfunction

   // One accepted character: update the parse and, on NUL, queue the expected result.
   function automatic void parse_char(logic [CHAR_WIDTH-1:0] c);
      parse_result_type res;
      if (prs_pos == 0) begin
         prs_radix    = cfg_radix;
         prs_unsigned = cfg_unsigned;
         if (prs_radix == RADIX_ONE || prs_radix > RADIX_MAX) prs_phase = PH_BAD;
      end
      if (c == CHAR_NUL) begin
         if (prs_phase == PH_BAD) begin
            res.value      = '0;
            res.end_offset = '0;
            res.status     = STAT_BAD;
         end else begin
            res.value      = (prs_neg ? (64'd0 - prs_acc) : prs_acc) & VAL_MASK;
            res.end_offset = prs_stop[OFFSET_WIDTH-1:0];
            res.status     = prs_sat ? STAT_SAT : STAT_OK;
         end
         expected_results.push_back(res);
         restart_string();
      end else begin
         feed_char(c);
         prs_pos = bumped(prs_pos);
      end
   endfunction

   function automatic void flag_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
   endfunction

   // ------------------------------------------------------------------
   // String generation
   // ------------------------------------------------------------------

   function automatic void queue_char(logic [CHAR_WIDTH-1:0] c);
      pending_chars.push_back(c);
      chars_queued++;
   endfunction

   // Queue a literal string and its terminating NUL.
   function automatic void queue_text(string s);
      for (int i = 0; i < s.len(); i++) queue_char(s[i]);
      queue_char(CHAR_NUL);
   endfunction

   // Digit character with random letter case.
   function automatic logic [CHAR_WIDTH-1:0] digit_char(int unsigned d);
      logic [CHAR_WIDTH-1:0] c;
      if (d < 10) begin
         c = CHAR_ZERO + CHAR_WIDTH'(d);
      end else begin
         c = CHAR_A_LOWER + CHAR_WIDTH'(d - 10);
         if ($urandom_range(0, 1) == 1) c = c ^ CHAR_CASE;
      end
      return c;
   endfunction

   function automatic void queue_digits(logic [RESULT_WIDTH-1:0] mag, int unsigned base);
      logic [CHAR_WIDTH-1:0]   digs[$];
      logic [RESULT_WIDTH-1:0] m;
      m = mag;
      do begin
         digs.push_front(digit_char(int'(m % 64'(base))));
         m = m / 64'(base);
      end while (m != 0);
      foreach (digs[i]) queue_char(digs[i]);
   endfunction

   // Mostly well-formed numbers: whitespace, sign, prefix, digits, trailing bytes.
   function automatic void queue_number_string();
      int unsigned             base;
      int unsigned             sel;
      bit                      hex_prefix;
      logic [RESULT_WIDTH-1:0] mag;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
         sel = $urandom_range(0, 5);
         queue_char(sel == 5 ? CHAR_SPACE : CHAR_TAB + CHAR_WIDTH'(sel));
      end
      sel = $urandom_range(0, 9);
      if (sel < 3) queue_char(CHAR_MINUS);
      else if (sel < 5) queue_char(CHAR_PLUS);
      hex_prefix = 1'b0;
      if ((cfg_radix == RADIX_AUTO || cfg_radix == RADIX_HEX) && $urandom_range(0, 2) == 0) begin
         queue_char(CHAR_ZERO);
         queue_char($urandom_range(0, 1) ? CHAR_X_UPPER : CHAR_X_LOWER);
         hex_prefix = 1'b1;
      end
      if (cfg_radix == RADIX_AUTO) begin
         base = hex_prefix ? 16 : 10;
      end else if (cfg_radix == RADIX_ONE || cfg_radix > RADIX_MAX) begin
         base = $urandom_range(2, 36);
      end else begin
         base = cfg_radix;
      end
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1: begin
            case ($urandom_range(0, 5))
               0: mag = 64'h7FFF_FFFF_FFFF_FFFE;
               1: mag = 64'h7FFF_FFFF_FFFF_FFFF;
               2: mag = 64'h8000_0000_0000_0000;
               3: mag = 64'h8000_0000_0000_0001;
               4: mag = 64'hFFFF_FFFF_FFFF_FFFE;
               default: mag = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
         end
         2: mag = '0;
         3, 4, 5: mag = 64'($urandom_range(0, 65535));
         default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      // Occasionally leave the digits out, e.g. a bare sign or a bare 0x.
      if ($urandom_range(0, 15) != 0) queue_digits(mag, base);
      // Extra digits push large values past the limit.
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) queue_char(digit_char($urandom_range(0, base - 1)));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) queue_char(CHAR_WIDTH'($urandom_range(1, 255)));
      queue_char(CHAR_NUL);
   endfunction

   // Raw bytes, any value but NUL, then the terminator.
   function automatic void queue_noise_string();
      repeat ($urandom_range(0, 6)) queue_char(CHAR_WIDTH'($urandom_range(1, 255)));
      queue_char(CHAR_NUL);
   endfunction

   // ------------------------------------------------------------------
   // Clock, configuration writes and idle waits
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Write one register and mirror it once the beat is taken.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_RADIX) cfg_radix = data[RADIX_WIDTH-1:0];
      else if (idx == CSR_UNSIGNED) cfg_unsigned = data[0];
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold until every queued character is taken and every result has come back,
   // then let the pipeline settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (chars_accepted != chars_queued || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle_mode(input int unsigned mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
         default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Driver: present one character per beat, hold it while the sink stalls
   // ------------------------------------------------------------------

   always @(posedge clock) begin : drive_chars
      if (reset) begin
         req_bus.valid <= 1'b0;
         cfg_radix      = RADIX_RESET;
         cfg_unsigned   = 1'b0;
         restart_string();
      end else begin
         // Predict on the beat just taken, before picking the next one.
         if (req_bus.valid && req_bus.ready) begin
            parse_char(req_bus.char_code);
            chars_accepted++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the current beat
         end else if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_bus.valid     <= 1'b1;
            req_bus.char_code <= pending_chars.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare every result beat against the oldest expectation
   // ------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      parse_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               flag_mismatch("unexpected result beat, value", '0, rsp_bus.value);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.value !== want.value)
                  flag_mismatch("value", want.value, rsp_bus.value);
               if (rsp_bus.end_offset !== want.end_offset)
                  flag_mismatch("end_offset", 64'(want.end_offset), 64'(rsp_bus.end_offset));
               if (rsp_bus.status !== want.status)
                  flag_mismatch("status", 64'(want.status), 64'(rsp_bus.status));
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Run limit
   // ------------------------------------------------------------------

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------

   initial begin
      int unsigned phase_start;
      logic [RADIX_WIDTH-1:0] next_radix;
      logic                   next_unsigned;

      // Drive every input to a known value before the first edge.
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      chars_queued      = 0;
      chars_accepted    = 0;
      error_count       = 0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings in the reset setting (decimal, signed).
      queue_text("");                       // no digits at all
      queue_text(" \t-12x");                // whitespace, sign, digits, trailing byte
      queue_text("+");                      // sign with nothing after it
      queue_text("-9223372036854775808");   // exact signed minimum, no saturation
      queue_text("99999999999999999999");   // overflow, more digits after saturation
      queue_char(CHAR_NINE);                // top-half byte values end the number
      queue_char(8'hFF);
      queue_char(8'h80);
      queue_char(CHAR_NUL);
      wait_idle();

      // Random phases: new register setting and new idle pattern each time.
      for (int p = 0; p < 14; p++) begin
         if (p < 12) begin
            next_radix    = radix_plan[p];
            next_unsigned = unsigned_plan[p];
         end else begin
            next_radix    = RADIX_WIDTH'($urandom_range(0, 63));
            next_unsigned = 1'($urandom_range(0, 1));
         end
         // Random upper data bits; only the register's own bits count.
         if (p % 2 == 0) begin
            write_reg(CSR_RADIX, {2'($urandom), next_radix});
            write_reg(CSR_UNSIGNED, {7'($urandom), next_unsigned});
         end else begin
            write_reg(CSR_UNSIGNED, {7'($urandom), next_unsigned});
            write_reg(CSR_RADIX, {2'($urandom), next_radix});
         end
         // An index with no register behind it must change nothing.
         if (p % 5 == 2) write_reg(CSR_SPARE_INDEX, 8'($urandom));
         set_idle_mode(p % 4);

         phase_start = chars_queued;
         while (chars_queued - phase_start < PHASE_CHARS) begin
            if ($urandom_range(0, 4) == 0) queue_noise_string();
            else queue_number_string();
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
